// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers, included by the scatter-accumulate RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define FFSA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true at a clock edge outside reset.
`define FFSA_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define FFSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFSA_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Face flux scatter-accumulate package
// Widths, request codes, shared structs and the output saturation function.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int TYPE_W        = 2;
	localparam int CELL_W        = 10;
	localparam int VAL_W         = 32;
	localparam int ACC_W         = 40;
	localparam int FRAC_W        = 16;
	localparam int DVD_W         = ACC_W + FRAC_W;
	localparam int DIV_STEPS     = DVD_W;
	localparam int NUM_CELLS_DEF = 1024;

	localparam logic [TYPE_W-1:0] REQ_INTERIOR = 2'd0;
	localparam logic [TYPE_W-1:0] REQ_BOUNDARY = 2'd1;
	localparam logic [TYPE_W-1:0] REQ_READ     = 2'd2;

	typedef struct packed {
		logic             start;
		logic [ACC_W-1:0] mag;
		logic [VAL_W-1:0] vol;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             big;
		logic [VAL_W-1:0] quot;
	} div_res_t;

	typedef struct packed {
		logic [VAL_W-1:0] result;
		logic             sat;
	} sat_res_t;

	// Clamp a sign and magnitude to a signed 32-bit word. The big flag means
	// the magnitude has bits above the low 32.
	function automatic sat_res_t saturate(input logic neg, input logic big,
			input logic [VAL_W-1:0] mag);
		sat_res_t r;
		if (neg) begin
			if (big || mag > {1'b1, {(VAL_W-1){1'b0}}}) begin
				r.result = {1'b1, {(VAL_W-1){1'b0}}};
				r.sat    = 1'b1;
			end else begin
				r.result = VAL_W'(~mag + 1'b1);
				r.sat    = 1'b0;
			end
		end else begin
			if (big || mag[VAL_W-1]) begin
				r.result = {1'b0, {(VAL_W-1){1'b1}}};
				r.sat    = 1'b1;
			end else begin
				r.result = mag;
				r.sat    = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/ffsa_req_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one face update or cell read word.
// ----------------------------------------------------------------------------
interface ffsa_req_if import ffsa_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [TYPE_W-1:0]        req_type;
	logic [CELL_W-1:0]        first_cell;
	logic [CELL_W-1:0]        second_cell;
	logic signed [VAL_W-1:0]  face_value;
	logic [VAL_W-1:0]         cell_volume;

	modport source (
		output valid, req_type, first_cell, second_cell, face_value, cell_volume,
		input  ready
	);
	modport sink (
		input  valid, req_type, first_cell, second_cell, face_value, cell_volume,
		output ready
	);
endinterface

// ===== hw/rtl/ffsa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the result word of one cell read.
// ----------------------------------------------------------------------------
interface ffsa_rsp_if import ffsa_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CELL_W-1:0]        cell_index;
	logic signed [VAL_W-1:0]  cell_result;
	logic                     divide_error;
	logic                     saturated;

	modport source (
		output valid, cell_index, cell_result, divide_error, saturated,
		input  ready
	);
	modport sink (
		input  valid, cell_index, cell_result, divide_error, saturated,
		output ready
	);
endinterface

// ===== hw/rtl/face_flux_scatter_accumulate.sv =====
// ----------------------------------------------------------------------------
// Face flux scatter-accumulate
// Per-cell accumulation of face fluxes with read-and-clear and volume division.
// ----------------------------------------------------------------------------
// Usage:
// Words arrive on the req channel. An interior face adds its value to the owner
// cell and then subtracts it from (integrate mode) or adds it to (sum mode) the
// neighbour cell. A boundary face adds its value to one cell. A read returns
// the cell sum on the rsp channel and clears the entry; in integrate mode the
// sum is divided by the cell volume, with divide_error set for a zero volume.
// Results saturate to signed 32 bits. Cells at or above NUM_CELLS are ignored.
// Each cell update is a read-modify-write through the single memory port pair,
// so a boundary face passes the sequencer through one update state and an
// interior face through two. A read in integrate mode waits on the serial
// divider, which produces one of its 56 quotient bits each cycle.
// The request side is ready only while the sequencer is idle.
// After reset the store is swept to zero, one cell a cycle, and the request side
// stays not ready until the sweep ends; mode resets to integrate.
// The result sits in an output register. While the receiver stalls, new words
// are still taken, and only a further read waits until that register is free.
// The user writes mode via cfg_wr_en and cfg_wr_data only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module face_flux_scatter_accumulate import ffsa_pkg::*; #(
	parameter int NUM_CELLS = NUM_CELLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	ffsa_req_if.sink    req,
	ffsa_rsp_if.source  rsp
);

	localparam int AW = $clog2(NUM_CELLS);

	// Sequencer states.
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_ADD1  = 3'd2;
	localparam logic [2:0] ST_RD2   = 3'd3;
	localparam logic [2:0] ST_ADD2  = 3'd4;
	localparam logic [2:0] ST_RDCLR = 3'd5;
	localparam logic [2:0] ST_DIV   = 3'd6;
	localparam logic [2:0] ST_FIN   = 3'd7;

	logic [2:0]              state_q;
	logic [2:0]              state_d;
	logic                    mode_q;

	// Captured request word.
	logic [TYPE_W-1:0]       kind_q;
	logic [CELL_W-1:0]       c1_q;
	logic [CELL_W-1:0]       c2_q;
	logic [VAL_W-1:0]        val_q;
	logic [VAL_W-1:0]        vol_q;

	// Read result before saturation.
	logic                    neg_q;
	logic                    big_q;
	logic [VAL_W-1:0]        quo_q;
	logic                    derr_q;

	// Output register.
	logic                    rsp_valid_q;
	logic [CELL_W-1:0]       rsp_index_q;
	logic [VAL_W-1:0]        rsp_result_q;
	logic                    rsp_derr_q;
	logic                    rsp_sat_q;

	logic                    in_acc;
	logic                    out_free;
	logic                    out_load;
	logic                    c1_ok;
	logic                    c2_ok;

	logic [AW-1:0]           st_rd_addr;
	logic [ACC_W-1:0]        st_rd_data;
	logic                    st_wr_en;
	logic [AW-1:0]           st_wr_addr;
	logic [ACC_W-1:0]        st_wr_data;
	logic                    st_clearing;

	logic [ACC_W-1:0]        val_ext;
	logic                    sub;
	logic [ACC_W-1:0]        add_sum;
	logic [ACC_W-1:0]        raw;
	logic                    raw_neg;
	logic [ACC_W-1:0]        raw_mag;
	logic                    vol_zero;

	div_req_t                div_req;
	div_res_t                div_res;
	sat_res_t                sat_r;

	ffsa_store #(
		.NUM_CELLS (NUM_CELLS)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (st_rd_addr),
		.rd_data  (st_rd_data),
		.wr_en    (st_wr_en),
		.wr_addr  (st_wr_addr),
		.wr_data  (st_wr_data),
		.clearing (st_clearing)
	);

	ffsa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign in_acc    = req.valid && req.ready;
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Cells outside the store are dropped on update and read as zero.
	assign c1_ok    = (32'(c1_q) < NUM_CELLS);
	assign c2_ok    = (32'(c2_q) < NUM_CELLS);
	assign vol_zero = (vol_q == '0);

	// The one accumulator adder: the neighbour of an interior face subtracts
	// in integrate mode, every other update adds.
	assign val_ext = {{(ACC_W-VAL_W){val_q[VAL_W-1]}}, val_q};
	assign sub     = (state_q == ST_ADD2) && !mode_q;
	assign add_sum = sub ? (st_rd_data - val_ext) : (st_rd_data + val_ext);

	// Sign and magnitude of the entry being read. The magnitude of the most
	// negative sum is 2^39, which still fits in 40 unsigned bits.
	assign raw     = c1_ok ? st_rd_data : '0;
	assign raw_neg = raw[ACC_W-1];
	assign raw_mag = raw_neg ? (ACC_W'(0) - raw) : raw;

	always_comb begin
		state_d      = state_q;
		st_wr_en     = 1'b0;
		st_wr_addr   = AW'(c1_q);
		st_wr_data   = add_sum;
		st_rd_addr   = (state_q == ST_RD2) ? AW'(c2_q) : AW'(req.first_cell);
		div_req.start = 1'b0;
		div_req.mag   = raw_mag;
		div_req.vol   = vol_q;
		out_load     = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				if (!st_clearing) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// The owner cell is read at the edge that accepts the word.
				if (in_acc) begin
					case (req.req_type)
						REQ_INTERIOR, REQ_BOUNDARY: state_d = ST_ADD1;
						REQ_READ:                   state_d = ST_RDCLR;
						default:                    state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADD1: begin
				st_wr_en = c1_ok;
				state_d  = (kind_q == REQ_INTERIOR) ? ST_RD2 : ST_IDLE;
			end
			ST_RD2: begin
				// Reading after the owner write keeps a face whose owner and
				// neighbour are the same cell correct.
				state_d = ST_ADD2;
			end
			ST_ADD2: begin
				st_wr_en   = c2_ok;
				st_wr_addr = AW'(c2_q);
				state_d    = ST_IDLE;
			end
			ST_RDCLR: begin
				st_wr_en   = c1_ok;
				st_wr_data = '0;
				if (!mode_q && !vol_zero) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_DIV: begin
				if (div_res.done) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			mode_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				mode_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			kind_q <= req.req_type;
			c1_q   <= req.first_cell;
			c2_q   <= req.second_cell;
			val_q  <= req.face_value;
			vol_q  <= req.cell_volume;
		end
	end

	// Sum mode returns the raw magnitude, integrate mode the quotient; a zero
	// volume in integrate mode gives a plain zero with the error flag.
	always_ff @(posedge clk) begin
		if (state_q == ST_RDCLR) begin
			derr_q <= !mode_q && vol_zero;
			neg_q  <= raw_neg && (mode_q || !vol_zero);
			quo_q  <= mode_q ? raw_mag[VAL_W-1:0] : '0;
			big_q  <= mode_q && (|raw_mag[ACC_W-1:VAL_W]);
		end else if ((state_q == ST_DIV) && div_res.done) begin
			quo_q <= div_res.quot;
			big_q <= div_res.big;
		end
	end

	assign sat_r = saturate(neg_q, big_q, quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp_index_q  <= c1_q;
			rsp_result_q <= sat_r.result;
			rsp_derr_q   <= derr_q;
			rsp_sat_q    <= sat_r.sat;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.cell_index   = rsp_index_q;
	assign rsp.cell_result  = rsp_result_q;
	assign rsp.divide_error = rsp_derr_q;
	assign rsp.saturated    = rsp_sat_q;

	// A new result word only ever appears out of the final sequencer state.
	`FFSA_ASSERT(a_rsp_from_fin, clk, arst_n, $rose(rsp.valid) |-> $past(state_q) == ST_FIN, "result word without a finished read")
	// The divider must not report completion to a sequencer that is not waiting.
	`FFSA_ASSERT(a_div_done_in_div, clk, arst_n, div_res.done |-> state_q == ST_DIV, "divider finished outside the divide state")
	// Updates must not race the clearing sweep for the write port.
	`FFSA_NEVER(a_no_wr_clearing, clk, arst_n, st_wr_en && st_clearing, "store update during clearing sweep")
	// A divide-error read yields zero, which can never be clamped.
	`FFSA_NEVER(a_derr_no_sat, clk, arst_n, rsp.valid && rsp.divide_error && rsp.saturated, "divide error with saturation")

endmodule

// ===== hw/rtl/ffsa_store.sv =====
// ----------------------------------------------------------------------------
// Cell accumulator store
// One-read one-write memory of 40-bit cell sums with a clearing pass after reset.
// ----------------------------------------------------------------------------
module ffsa_store import ffsa_pkg::*; #(
	parameter int NUM_CELLS = NUM_CELLS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [$clog2(NUM_CELLS)-1:0] rd_addr,
	output logic [ACC_W-1:0]             rd_data,
	input  logic                         wr_en,
	input  logic [$clog2(NUM_CELLS)-1:0] wr_addr,
	input  logic [ACC_W-1:0]             wr_data,
	output logic                         clearing
);

	localparam int AW = $clog2(NUM_CELLS);

	logic [ACC_W-1:0] mem_q [NUM_CELLS];
	logic [ACC_W-1:0] rd_data_q;
	logic [AW-1:0]    clr_cnt_q;
	logic             clearing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q  <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(NUM_CELLS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// The clearing pass owns the write port until every entry is zero.
	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_cnt_q] <= '0;
		end else if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data  = rd_data_q;
	assign clearing = clearing_q;

endmodule

// ===== hw/rtl/ffsa_div.sv =====
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division of (magnitude << 16) by the volume, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ffsa_div import ffsa_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_res_t res
);

	localparam int CNT_W = $clog2(DIV_STEPS);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] dvd_q;
	logic [VAL_W-1:0] vol_q;
	logic [VAL_W-1:0] rem_q;
	logic [VAL_W-1:0] quo_q;
	logic             big_q;

	logic [VAL_W:0]   rem_sh;
	logic             ge;
	logic [VAL_W-1:0] rem_nx;

	// The partial remainder stays below the volume, so the shifted value
	// fits in 33 bits and the difference fits back in 32.
	assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, vol_q};
	assign rem_nx = ge ? VAL_W'(rem_sh - {1'b0, vol_q}) : rem_sh[VAL_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= {req.mag, {FRAC_W{1'b0}}};
			vol_q <= req.vol;
			rem_q <= '0;
			quo_q <= '0;
			big_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			rem_q <= rem_nx;
			quo_q <= {quo_q[VAL_W-2:0], ge};
			big_q <= big_q | quo_q[VAL_W-1];
		end
	end

	assign res.done = done_q;
	assign res.big  = big_q;
	assign res.quot = quo_q;

endmodule
